/* design/tbi_pkg.sv */
// Shared types and constants for the triangle barycentric interpolator.
package tbi_pkg;

    localparam int TOL_BITS = 16;

    // Sideband status of one result.
    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } tbi_flags_t;

    // Per-stage control: valid bit and the advance enable for that stage.
    typedef struct packed {
        logic vld;
        logic adv;
    } tbi_stage_t;

endpackage

/* design/tbi_setup.sv */
// Front stages: vertex differences, then determinant and numerator products.
module tbi_setup #(
    parameter int CW = 24,
    parameter int VW = 32
) (
    input  logic                 clk,
    input  logic                 en0,
    input  logic                 en1,
    input  logic signed [CW-1:0] x0,
    input  logic signed [CW-1:0] y0,
    input  logic signed [CW-1:0] x1,
    input  logic signed [CW-1:0] y1,
    input  logic signed [CW-1:0] x2,
    input  logic signed [CW-1:0] y2,
    input  logic signed [CW-1:0] px,
    input  logic signed [CW-1:0] py,
    input  logic signed [VW-1:0] v0_in,
    input  logic signed [VW-1:0] v1_in,
    input  logic signed [VW-1:0] v2_in,
    output logic signed [2*CW+2:0] det,
    output logic signed [2*CW+2:0] n1,
    output logic signed [2*CW+2:0] n2,
    output logic signed [VW-1:0] v0_out,
    output logic signed [VW-1:0] v1_out,
    output logic signed [VW-1:0] v2_out
);
    import tbi_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * CW + 3;

    logic signed [DW-1:0] a_reg, b_reg, c_reg, d_reg, dx_reg, dy_reg;
    logic signed [VW-1:0] va_reg, vb_reg, vc_reg;
    logic signed [PW-1:0] det_reg, n1_reg, n2_reg;
    logic signed [VW-1:0] vd_reg, ve_reg, vf_reg;

    // full-width products of the differences
    logic signed [2*DW-1:0] p_ad, p_bc, p_ddx, p_bdy, p_ady, p_cdx;
    assign p_ad  = a_reg * d_reg;
    assign p_bc  = b_reg * c_reg;
    assign p_ddx = d_reg * dx_reg;
    assign p_bdy = b_reg * dy_reg;
    assign p_ady = a_reg * dy_reg;
    assign p_cdx = c_reg * dx_reg;

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            a_reg  <= DW'(x0) - DW'(x2);
            b_reg  <= DW'(x1) - DW'(x2);
            c_reg  <= DW'(y0) - DW'(y2);
            d_reg  <= DW'(y1) - DW'(y2);
            dx_reg <= DW'(px) - DW'(x2);
            dy_reg <= DW'(py) - DW'(y2);
            va_reg <= v0_in;
            vb_reg <= v1_in;
            vc_reg <= v2_in;
        end
        if (en1)
        begin
            det_reg <= PW'(p_ad) - PW'(p_bc);
            n1_reg  <= PW'(p_ddx) - PW'(p_bdy);
            n2_reg  <= PW'(p_ady) - PW'(p_cdx);
            vd_reg  <= va_reg;
            ve_reg  <= vb_reg;
            vf_reg  <= vc_reg;
        end
    end

    assign det    = det_reg;
    assign n1     = n1_reg;
    assign n2     = n2_reg;
    assign v0_out = vd_reg;
    assign v1_out = ve_reg;
    assign v2_out = vf_reg;
endmodule

/* design/tbi_div.sv */
// Pipelined restoring divider: |num|/|den| to FRAC fraction bits plus a round bit,
// one quotient bit per stage, rounded half away from zero and saturated.
module tbi_div #(
    parameter int NW   = 51,
    parameter int FRAC = 16,
    parameter int WW   = 20,
    parameter int SW   = 32
) (
    input  logic                 clk,
    input  logic [WW+3:0]        en,
    input  logic signed [NW-1:0] num,
    input  logic signed [NW-1:0] den,
    input  logic [SW-1:0]        side_in,
    output logic signed [WW-1:0] quo,
    output logic [SW-1:0]        side_out
);
    import tbi_pkg::*;

    localparam int IB    = WW - FRAC;       // integer quotient bits before overflow
    localparam int STEPS = IB + FRAC + 1;   // integer, fraction and round bits
    localparam int UW    = NW + 1;
    localparam int RW    = UW + STEPS;

    logic [UW-1:0]    un_reg, ud_reg;
    logic             neg_reg;
    logic [SW-1:0]    s0_reg;

    logic [RW-1:0]    rem_reg [STEPS+1];
    logic [UW-1:0]    dd_reg  [STEPS+1];
    logic [STEPS-1:0] q_reg   [STEPS+1];
    logic             ng_reg  [STEPS+1];
    logic             ovf_reg [STEPS+1];
    logic [SW-1:0]    sd_reg  [STEPS+1];

    logic signed [WW-1:0] quo_reg;
    logic [SW-1:0]        so_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            un_reg  <= num[NW-1] ? UW'(-$signed({num[NW-1], num})) : UW'(num);
            ud_reg  <= den[NW-1] ? UW'(-$signed({den[NW-1], den})) : UW'(den);
            neg_reg <= num[NW-1] ^ den[NW-1];
            s0_reg  <= side_in;
        end
        if (en[1])
        begin
            // quotient integer part of IB bits fits iff un < ud << IB
            // dividend scaled by 2^(FRAC+1) so the low quotient bits are fraction and round
            rem_reg[0] <= RW'(un_reg) << (FRAC + 1);
            dd_reg[0]  <= ud_reg;
            q_reg[0]   <= '0;
            ng_reg[0]  <= neg_reg;
            ovf_reg[0] <= ({IB'(0), un_reg} >= {ud_reg, IB'(0)});
            sd_reg[0]  <= s0_reg;
        end
    end

    // Stage k produces quotient bit with weight 2^(IB-1-k) of the integer-extended value.
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [RW-1:0] trial;
        assign trial = RW'(dd_reg[k]) << (STEPS - 1 - k);
        always_ff @(posedge clk)
        begin
            if (en[k+2])
            begin
                if (rem_reg[k] >= trial)
                begin
                    rem_reg[k+1] <= rem_reg[k] - trial;
                    q_reg[k+1]   <= q_reg[k] | (STEPS'(1) << (STEPS - 1 - k));
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    q_reg[k+1]   <= q_reg[k];
                end
                dd_reg[k+1]  <= dd_reg[k];
                ng_reg[k+1]  <= ng_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                sd_reg[k+1]  <= sd_reg[k];
            end
        end
    end

    logic [WW:0]          mag;
    logic signed [WW+1:0] sv;
    logic signed [WW-1:0] sat;
    always_comb
    begin
        // q holds value*2 (round bit in lsb); add it in for half away from zero
        mag = (WW+1)'(q_reg[STEPS] >> 1) + (WW+1)'(q_reg[STEPS][0]);
        if (ovf_reg[STEPS])
            mag = (WW+1)'(1) << WW;
        sv = ng_reg[STEPS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (sv > $signed((WW+2)'((1 << (WW-1)) - 1)))
            sat = {1'b0, {(WW-1){1'b1}}};
        else if (sv < -$signed((WW+2)'(1 << (WW-1))))
            sat = {1'b1, {(WW-1){1'b0}}};
        else
            sat = WW'(sv);
    end

    always_ff @(posedge clk)
    begin
        if (en[STEPS+2])
        begin
            quo_reg <= sat;
            so_reg  <= sd_reg[STEPS];
        end
    end

    assign quo      = quo_reg;
    assign side_out = so_reg;
endmodule

/* design/tbi_blend.sv */
// Back stages: weight times value products, sum, round, saturate, inside test, degenerate zeroing.
module tbi_blend #(
    parameter int FRAC = 16,
    parameter int WW   = 20,
    parameter int VW   = 32
) (
    input  logic                 clk,
    input  logic [2:0]           en,
    input  logic signed [WW-1:0] w0,
    input  logic signed [WW-1:0] w1,
    input  logic signed [WW-1:0] w2,
    input  logic signed [VW-1:0] v0,
    input  logic signed [VW-1:0] v1,
    input  logic signed [VW-1:0] v2,
    input  logic                 degen,
    input  logic [tbi_pkg::TOL_BITS-1:0] tol,
    output logic signed [WW-1:0] q0,
    output logic signed [WW-1:0] q1,
    output logic signed [WW-1:0] q2,
    output logic signed [VW-1:0] interp,
    output tbi_pkg::tbi_flags_t  flags
);
    import tbi_pkg::*;

    localparam int MW = WW + VW;
    localparam int SW = MW + 2;
    localparam int CB = WW + TOL_BITS;

    logic signed [MW-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [WW-1:0] a0_reg, a1_reg, a2_reg, b0_reg, b1_reg, b2_reg;
    logic                 dg_a_reg, dg_b_reg, in_a_reg, in_b_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [WW-1:0] c0_reg, c1_reg, c2_reg;
    logic signed [VW-1:0] iv_reg;
    tbi_flags_t           fl_reg;

    logic signed [MW-1:0] m0, m1, m2;
    assign m0 = w0 * v0;
    assign m1 = w1 * v1;
    assign m2 = w2 * v2;

    logic signed [CB:0] ntol;
    logic               inside_now;
    assign ntol       = -$signed({1'b0, CB'(tol)});
    assign inside_now = ((CB+1)'(w0) >= ntol) &&
                        ((CB+1)'(w1) >= ntol) &&
                        ((CB+1)'(w2) >= ntol);

    logic signed [SW-1:0] rsum;
    logic signed [SW-FRAC-1:0] rq;
    logic signed [VW-1:0] isat;
    always_comb
    begin
        rsum = sum_reg + SW'(1 << (FRAC - 1));
        rq   = (SW-FRAC)'(rsum >>> FRAC);
        if (rq > $signed((SW-FRAC)'({1'b0, {(VW-1){1'b1}}})))
            isat = {1'b0, {(VW-1){1'b1}}};
        else if (rq < -$signed((SW-FRAC)'({1'b0, {(VW-1){1'b1}}})) - 1)
            isat = {1'b1, {(VW-1){1'b0}}};
        else
            isat = VW'(rq);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p0_reg   <= m0;
            p1_reg   <= m1;
            p2_reg   <= m2;
            a0_reg   <= w0;
            a1_reg   <= w1;
            a2_reg   <= w2;
            dg_a_reg <= degen;
            in_a_reg <= inside_now;
        end
        if (en[1])
        begin
            sum_reg  <= SW'(p0_reg) + SW'(p1_reg) + SW'(p2_reg);
            b0_reg   <= a0_reg;
            b1_reg   <= a1_reg;
            b2_reg   <= a2_reg;
            dg_b_reg <= dg_a_reg;
            in_b_reg <= in_a_reg;
        end
        if (en[2])
        begin
            c0_reg <= dg_b_reg ? '0 : b0_reg;
            c1_reg <= dg_b_reg ? '0 : b1_reg;
            c2_reg <= dg_b_reg ? '0 : b2_reg;
            iv_reg <= dg_b_reg ? '0 : isat;
            fl_reg <= '{inside_res: in_b_reg & ~dg_b_reg, degenerate: dg_b_reg};
        end
    end

    assign q0     = c0_reg;
    assign q1     = c1_reg;
    assign q2     = c2_reg;
    assign interp = iv_reg;
    assign flags  = fl_reg;
endmodule

/* design/triangle_barycentric_interpolator.sv */
// Top level of the triangle barycentric interpolator pipeline.
//
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | 8 coords, 3 node values
//  m_axis  | out | m_axis_tvalid/tready   | 3 weights, value, 2 flags in tuser
//  cfg     | in  | cfg_valid/cfg_ready    | inside_tolerance
//
// One item per cycle unless the output stalls. The pipe is the setup stages,
// the one-bit-per-stage divider and the blend stages. All stages advance
// together when the output register is empty or being read, so a stall
// freezes the whole pipe. Reset clears valid bits and the tolerance register.
module triangle_barycentric_interpolator #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, point_x, point_y,
    // value0, value1, value2 (low bit up), zero filled to bytes
    input  logic [((8*COORD_BITS+3*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // weight0, weight1, weight2, interpolated (low bit up), zero filled
    output logic [((3*(FRAC_BITS+4)+VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // inside_res, degenerate
    output logic [1:0] m_axis_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [tbi_pkg::TOL_BITS-1:0] cfg_data
);
    import tbi_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int VW    = VALUE_BITS;
    localparam int WW    = FRAC_BITS + 4;
    localparam int NW    = 2 * CW + 3;
    localparam int DST   = WW + 4;           // divider stages incl. abs, init and output
    localparam int DEPTH = 2 + DST + 3;
    localparam int OW    = ((3*WW+VW+7)/8)*8;
    localparam int SDW   = 3 * VW + 1;

    logic [TOL_BITS-1:0] tol_reg;
    logic [DEPTH-1:0]    vld_reg;
    logic                adv;
    tbi_stage_t          head;

    assign adv           = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;
    assign head          = '{vld: s_axis_tvalid, adv: adv};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            tol_reg <= '0;
        end
        else
        begin
            if (head.adv)
                vld_reg <= {vld_reg[DEPTH-2:0], head.vld};
            if (cfg_valid && cfg_ready)
                tol_reg <= cfg_data;
        end
    end

    logic [DEPTH-1:0] en;
    assign en = {DEPTH{adv}};

    logic signed [NW-1:0] det, n1, n2;
    logic signed [VW-1:0] v0, v1, v2;

    tbi_setup #(.CW(CW), .VW(VW)) u_setup (
        .clk(clk), .en0(en[0]), .en1(en[1]),
        .x0(s_axis_tdata[0*CW +: CW]), .y0(s_axis_tdata[1*CW +: CW]),
        .x1(s_axis_tdata[2*CW +: CW]), .y1(s_axis_tdata[3*CW +: CW]),
        .x2(s_axis_tdata[4*CW +: CW]), .y2(s_axis_tdata[5*CW +: CW]),
        .px(s_axis_tdata[6*CW +: CW]), .py(s_axis_tdata[7*CW +: CW]),
        .v0_in(s_axis_tdata[8*CW +: VW]), .v1_in(s_axis_tdata[8*CW+VW +: VW]),
        .v2_in(s_axis_tdata[8*CW+2*VW +: VW]),
        .det(det), .n1(n1), .n2(n2), .v0_out(v0), .v1_out(v1), .v2_out(v2)
    );

    // Degenerate case: divide by one to keep the divider clean; blend zeroes it.
    logic                 dz;
    logic signed [NW-1:0] dsafe, n3;
    logic [SDW-1:0]       side;
    assign dz    = (det == '0);
    assign dsafe = dz ? NW'(1) : det;
    assign n3    = det - n1 - n2;
    assign side  = {dz, v2, v1, v0};

    logic signed [WW-1:0] w0, w1, w2;
    logic [SDW-1:0]       side_q;
    logic                 dz1_q, dz2_q;

    tbi_div #(.NW(NW), .FRAC(FRAC_BITS), .WW(WW), .SW(SDW)) u_div0 (
        .clk(clk), .en(en[DST+1:2]), .num(n1), .den(dsafe),
        .side_in(side), .quo(w0), .side_out(side_q)
    );
    tbi_div #(.NW(NW), .FRAC(FRAC_BITS), .WW(WW), .SW(1)) u_div1 (
        .clk(clk), .en(en[DST+1:2]), .num(n2), .den(dsafe),
        .side_in(dz), .quo(w1), .side_out(dz1_q)
    );
    tbi_div #(.NW(NW), .FRAC(FRAC_BITS), .WW(WW), .SW(1)) u_div2 (
        .clk(clk), .en(en[DST+1:2]), .num(n3), .den(dsafe),
        .side_in(dz), .quo(w2), .side_out(dz2_q)
    );

    logic signed [WW-1:0] o0, o1, o2;
    logic signed [VW-1:0] oi;
    tbi_flags_t           fl;

    tbi_blend #(.FRAC(FRAC_BITS), .WW(WW), .VW(VW)) u_blend (
        .clk(clk), .en(en[DEPTH-1:DEPTH-3]),
        .w0(w0), .w1(w1), .w2(w2),
        .v0(side_q[0 +: VW]), .v1(side_q[VW +: VW]), .v2(side_q[2*VW +: VW]),
        .degen(side_q[SDW-1] | (dz1_q & dz2_q)),
        .tol(tol_reg),
        .q0(o0), .q1(o1), .q2(o2), .interp(oi), .flags(fl)
    );

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata  = OW'({oi, o2, o1, o0});
    assign m_axis_tuser  = {fl.degenerate, fl.inside_res};

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tdata == '0)
        else $error("degenerate result not zero");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !s_axis_tvalid |=> !vld_reg[0])
        else $error("bubble not tracked");
`endif
endmodule
